@@ rtl/mutf8_pkg.sv @@
// ----------------------------------------------------------------------------
// Modified UTF-8 to UTF-8 package
// Shared constants and the record that passes from the decoder front end to
// the byte emitter through the result queue.
// ----------------------------------------------------------------------------
package mutf8_pkg;

    localparam int PEND_DEPTH  = 5;
    localparam int MAX_OUT     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  NUL_LEAD    = 8'hC0;
    localparam logic [7:0]  NUL_TRAIL   = 8'h80;
    localparam logic [7:0]  NUL_BYTE    = 8'h00;
    localparam logic [2:0]  TWO_TAG     = 3'b110;
    localparam logic [3:0]  THREE_TAG   = 4'b1110;
    localparam logic [1:0]  CONT_TAG    = 2'b10;
    localparam logic [3:0]  SUR_NIBBLE  = 4'hD;
    localparam logic [1:0]  HI_SUR_BITS = 2'b10;
    localparam logic [1:0]  LO_SUR_BITS = 2'b11;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [4:0]  FOUR_MARK   = 5'b11110;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    last;
        logic                    error;
    } mutf8_entry_t;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == CONT_TAG;
    endfunction

endpackage

@@ rtl/mutf8_front.sv @@
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder front end
// Holds partial sequences, classifies each request and queues the bytes or
// the error that it produces.
// ----------------------------------------------------------------------------
module mutf8_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output logic                   push,
    output mutf8_pkg::mutf8_entry_t entry,
    input  logic                   q_full
);
    import mutf8_pkg::*;

    logic [PEND_DEPTH-1:0][7:0] pend_reg;
    logic [PEND_DEPTH-1:0][7:0] pend_next;
    logic [2:0]                 pcnt_reg;
    logic [2:0]                 pcnt_next;
    logic                       disc_reg;
    logic                       disc_next;

    logic                       accept;
    logic [7:0]                 b0;
    logic                       is_two;
    logic                       is_three;
    logic                       emit;
    logic                       hold;
    logic                       err;
    logic [2:0]                 n;
    logic [MAX_OUT-1:0][7:0]    ob;
    logic [20:0]                cp;
    logic                       hi_sur;
    logic                       lo_sur;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b0       = (pcnt_reg == 3'd0) ? in_byte : pend_reg[0];
    assign is_two   = b0[7:5] == TWO_TAG;
    assign is_three = b0[7:4] == THREE_TAG;
    assign hi_sur   = (pend_reg[0][3:0] == SUR_NIBBLE) && (pend_reg[1][5:4] == HI_SUR_BITS);
    assign lo_sur   = (pend_reg[3][3:0] == SUR_NIBBLE) && (pend_reg[4][5:4] == LO_SUR_BITS);
    assign cp       = SUPP_BASE + {1'b0, pend_reg[1][3:0], pend_reg[2][5:0],
                                   pend_reg[4][3:0], in_byte[5:0]};

    always_comb
    begin
        emit = 1'b0;
        hold = 1'b0;
        err  = 1'b0;
        n    = 3'd0;
        ob   = '0;
        unique case (pcnt_reg)
            3'd0:
            begin
                if (is_two || is_three)
                begin
                    hold = 1'b1;
                end
                else
                begin
                    emit  = 1'b1;
                    n     = 3'd1;
                    ob[0] = in_byte;
                end
            end
            3'd1:
            begin
                if (is_two)
                begin
                    emit = 1'b1;
                    if (pend_reg[0] == NUL_LEAD && in_byte == NUL_TRAIL)
                    begin
                        n     = 3'd1;
                        ob[0] = NUL_BYTE;
                    end
                    else
                    begin
                        n     = 3'd2;
                        ob[0] = pend_reg[0];
                        ob[1] = in_byte;
                    end
                end
                else
                begin
                    hold = 1'b1;
                end
            end
            3'd2:
            begin
                if (!is_cont(pend_reg[1]) || !is_cont(in_byte))
                begin
                    err = 1'b1;
                end
                else if (hi_sur)
                begin
                    hold = 1'b1;
                end
                else
                begin
                    emit  = 1'b1;
                    n     = 3'd3;
                    ob[0] = pend_reg[0];
                    ob[1] = pend_reg[1];
                    ob[2] = in_byte;
                end
            end
            3'd3:
            begin
                if (in_byte[7:4] != THREE_TAG)
                begin
                    err = 1'b1;
                end
                else
                begin
                    hold = 1'b1;
                end
            end
            3'd4:
            begin
                hold = 1'b1;
            end
            default:
            begin
                if (!is_cont(pend_reg[4]) || !is_cont(in_byte) || !lo_sur)
                begin
                    err = 1'b1;
                end
                else
                begin
                    emit  = 1'b1;
                    n     = 3'd4;
                    ob[0] = {FOUR_MARK, cp[20:18]};
                    ob[1] = {CONT_TAG, cp[17:12]};
                    ob[2] = {CONT_TAG, cp[11:6]};
                    ob[3] = {CONT_TAG, cp[5:0]};
                end
            end
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        disc_next = disc_reg;
        push      = 1'b0;
        entry     = '0;
        if (accept)
        begin
            if (disc_reg)
            begin
                if (in_last)
                begin
                    disc_next = 1'b0;
                end
            end
            else
            begin
                pcnt_next = 3'd0;
                if (err || (hold && in_last && pcnt_reg > 3'd1))
                begin
                    push        = 1'b1;
                    entry.count = 3'd1;
                    entry.last  = 1'b1;
                    entry.error = 1'b1;
                    disc_next   = !in_last;
                end
                else if (hold && !in_last)
                begin
                    for (int k = 0; k < PEND_DEPTH; k++)
                    begin
                        if (pcnt_reg == 3'(k))
                        begin
                            pend_next[k] = in_byte;
                        end
                    end
                    pcnt_next = 3'(pcnt_reg + 3'd1);
                end
                else if (hold)
                begin
                    push       = 1'b1;
                    entry.last = 1'b1;
                    if (pcnt_reg == 3'd0)
                    begin
                        entry.count    = 3'd1;
                        entry.bytes[0] = in_byte;
                    end
                    else
                    begin
                        entry.count    = 3'd2;
                        entry.bytes[0] = pend_reg[0];
                        entry.bytes[1] = in_byte;
                    end
                end
                else
                begin
                    push        = emit;
                    entry.count = n;
                    entry.bytes = ob;
                    entry.last  = in_last;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            disc_reg <= 1'b0;
        end
        else
        begin
            pcnt_reg <= pcnt_next;
            disc_reg <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= 3'(PEND_DEPTH))
        else $error("Held byte count exceeds the hold depth.");

    a_disc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> pcnt_reg == 3'd0)
        else $error("Bytes are held while the string is being dropped.");

endmodule

@@ rtl/mutf8_queue.sv @@
// ----------------------------------------------------------------------------
// Modified UTF-8 result queue
// A short register queue of result records between the decoder front end
// and the byte emitter.
// ----------------------------------------------------------------------------
module mutf8_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mutf8_pkg::mutf8_entry_t wr_entry,
    output logic                    full,
    input  logic                    pop,
    output mutf8_pkg::mutf8_entry_t rd_entry,
    output logic                    empty
);
    import mutf8_pkg::*;

    mutf8_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Result record pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("Result record popped from an empty queue.");

endmodule

@@ rtl/mutf8_back.sv @@
// ----------------------------------------------------------------------------
// Modified UTF-8 byte emitter
// Walks the record at the head of the queue and places one result byte per
// cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module mutf8_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mutf8_pkg::mutf8_entry_t head,
    input  logic                    q_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    out_last,
    output logic                    out_error
);
    import mutf8_pkg::*;

    localparam int IDX_W = $clog2(MAX_OUT);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             last_reg;
    logic             last_next;
    logic             error_reg;
    logic             error_next;
    logic             advance;
    logic             final_byte;

    assign advance    = !valid_reg || out_ready;
    assign final_byte = 3'(idx_reg) == 3'(head.count - 3'd1);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        error_next = error_reg;
        pop        = 1'b0;
        if (advance)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                byte_next  = head.bytes[idx_reg];
                last_next  = head.last && final_byte;
                error_next = head.error;
                if (final_byte)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_error = error_reg;

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && error_reg |-> last_reg && byte_reg == NUL_BYTE)
        else $error("Error result is not a single closing zero byte.");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> idx_reg == '0)
        else $error("Byte index is not at the start while the queue is empty.");

endmodule

@@ rtl/modified_utf8_to_utf8.sv @@
// ----------------------------------------------------------------------------
// Modified UTF-8 to UTF-8 converter
// Converts a byte stream of modified UTF-8 strings to standard UTF-8.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  in_byte, in_last
//   out      out_valid/ out_ready out_byte, out_last, out_error
//
// One input request is taken per cycle while the result queue has room.
// The emitter gives one output byte per cycle while the output is not stalled,
// so a request that closes a surrogate pair yields four output bytes.
// The first output byte of a request passes through the result queue and then
// the output register after the request is accepted.
// Reset clears the held sequence, the drop flag, the queue and the output.
// A stalled output fills the four-record queue before the input stalls.
// ----------------------------------------------------------------------------
module modified_utf8_to_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_error
);
    import mutf8_pkg::*;

    mutf8_entry_t wr_entry;
    mutf8_entry_t head;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;

    mutf8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .entry    (wr_entry),
        .q_full   (q_full)
    );

    mutf8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (pop),
        .rd_entry (head),
        .empty    (q_empty)
    );

    mutf8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_error (out_error)
    );

endmodule

@@ verif/modified_utf8_to_utf8_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 to UTF-8 converter testbench
// Sends modified UTF-8 strings with random bursts and gaps on the input while
// the output stalls on its own random pattern. A scoreboard predicts the
// standard UTF-8 bytes, the string ends and the error results, and checks
// them in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
} utf8_result_t;

localparam logic [7:0]  NUL_LEAD    = 8'hC0;
localparam logic [7:0]  NUL_TRAIL   = 8'h80;
localparam logic [7:0]  NUL_BYTE    = 8'h00;
localparam logic [15:0] SUR_HI_BASE = 16'hD800;
localparam logic [15:0] SUR_HI_TOP  = 16'hDBFF;
localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
localparam logic [15:0] SUR_LO_TOP  = 16'hDFFF;
localparam logic [20:0] SUPP_BASE   = 21'h10000;

class utf8_scoreboard;
    logic [7:0]   held [5];
    int           held_cnt;
    bit           dropping;
    utf8_result_t expected_q [$];
    int           errors;

    function new();
        held_cnt = 0;
        dropping = 0;
        errors   = 0;
    endfunction

    // Returns 0 when the request falls in the dropped tail of a failed string.
    function bit note_request(logic [7:0] b, logic last);
        logic [7:0] seq [6];
        logic [7:0] out_bytes [$];
        int         cnt;
        bit         err;
        bit         hold;
        bit         two;
        bit         three;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [20:0] cp;
        if (dropping)
        begin
            if (last)
                dropping = 0;
            return 0;
        end
        err  = 0;
        hold = 0;
        for (int i = 0; i < held_cnt; i++)
            seq[i] = held[i];
        cnt = held_cnt;
        seq[cnt] = b;
        cnt++;
        two   = seq[0][7:5] == 3'b110;
        three = seq[0][7:4] == 4'b1110;
        case (cnt)
            1:
            begin
                if (two || three)
                    hold = 1;
                else
                    out_bytes.push_back(b);
            end
            2:
            begin
                if (two)
                begin
                    if (seq[0] == NUL_LEAD && seq[1] == NUL_TRAIL)
                        out_bytes.push_back(NUL_BYTE);
                    else
                    begin
                        out_bytes.push_back(seq[0]);
                        out_bytes.push_back(seq[1]);
                    end
                end
                else
                    hold = 1;
            end
            3:
            begin
                if (seq[1][7:6] != 2'b10 || seq[2][7:6] != 2'b10)
                    err = 1;
                else
                begin
                    hi = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
                    if (hi >= SUR_HI_BASE && hi <= SUR_HI_TOP)
                        hold = 1;
                    else
                    begin
                        out_bytes.push_back(seq[0]);
                        out_bytes.push_back(seq[1]);
                        out_bytes.push_back(seq[2]);
                    end
                end
            end
            4:
            begin
                if (seq[3][7:4] != 4'b1110)
                    err = 1;
                else
                    hold = 1;
            end
            5:
                hold = 1;
            default:
            begin
                if (seq[4][7:6] != 2'b10 || seq[5][7:6] != 2'b10)
                    err = 1;
                else
                begin
                    hi = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
                    lo = {seq[3][3:0], seq[4][5:0], seq[5][5:0]};
                    if (lo < SUR_LO_BASE || lo > SUR_LO_TOP)
                        err = 1;
                    else
                    begin
                        cp = SUPP_BASE + ((21'(hi - SUR_HI_BASE) << 10) |
                                          21'(lo - SUR_LO_BASE));
                        out_bytes.push_back({5'b11110, cp[20:18]});
                        out_bytes.push_back({2'b10, cp[17:12]});
                        out_bytes.push_back({2'b10, cp[11:6]});
                        out_bytes.push_back({2'b10, cp[5:0]});
                    end
                end
            end
        endcase
        held_cnt = 0;
        if (!err && hold)
        begin
            if (last)
            begin
                if (cnt <= 2)
                begin
                    for (int i = 0; i < cnt; i++)
                        out_bytes.push_back(seq[i]);
                end
                else
                    err = 1;
            end
            else
            begin
                for (int i = 0; i < cnt; i++)
                    held[i] = seq[i];
                held_cnt = cnt;
            end
        end
        if (err)
        begin
            expected_q.push_back(utf8_result_t'{NUL_BYTE, 1'b1, 1'b1});
            dropping = !last;
            return 1;
        end
        foreach (out_bytes[i])
            expected_q.push_back(utf8_result_t'{out_bytes[i],
                                 last && (i == out_bytes.size() - 1), 1'b0});
        return 1;
    endfunction

    function void check_result(logic [7:0] data, logic last, logic error);
        utf8_result_t want;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: out_byte %h out_last %b out_error %b",
                   data, last, error);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (data !== want.data)
        begin
            $error("out_byte: expected %h, got %h", want.data, data);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("out_last: expected %b, got %b", want.last, last);
            errors++;
        end
        if (error !== want.error)
        begin
            $error("out_error: expected %b, got %b", want.error, error);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction
endclass

module modified_utf8_to_utf8_tb;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;

    utf8_scoreboard sb;
    int             processed;
    int             burst_left;
    bit             calm;

    modified_utf8_to_utf8 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_error (out_error)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] rand_non_cont();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b[7:6] == 2'b10)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void push_three(ref logic [7:0] text [$], input logic [15:0] v);
        text.push_back({4'hE, v[15:12]});
        text.push_back({2'b10, v[11:6]});
        text.push_back({2'b10, v[5:0]});
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        @(negedge clk);
        if (burst_left <= 0)
        begin
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        burst_left--;
        do
            @(posedge clk);
        while (!in_ready);
        if (sb.note_request(b, last))
            processed++;
    endtask

    task automatic send_string(logic [7:0] text [$]);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic add_segment(ref logic [7:0] text [$], inout bit ended);
        int          kind;
        int          pick;
        int          idx;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [7:0]  pair [$];
        kind = $urandom_range(0, 99);
        hi = SUR_HI_BASE | 16'($urandom_range(0, 1023));
        lo = SUR_LO_BASE | 16'($urandom_range(0, 1023));
        if (kind < 24)
            text.push_back(8'($urandom_range(0, 127)));
        else if (kind < 30)
        begin
            text.push_back(NUL_LEAD);
            text.push_back(NUL_TRAIL);
        end
        else if (kind < 40)
        begin
            text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            if ($urandom_range(0, 3) == 0)
                text.push_back(8'($urandom_range(0, 255)));
            else
                text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 54)
            push_three(text, 16'($urandom_range(0, 16'hFFFF)));
        else if (kind < 70)
        begin
            push_three(text, hi);
            push_three(text, lo);
        end
        else if (kind < 76)
        begin
            if ($urandom_range(0, 1))
                text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else
                text.push_back(8'($urandom_range(8'hF0, 8'hFF)));
        end
        else if (kind < 82)
        begin
            b0 = 8'($urandom_range(8'hE0, 8'hEF));
            b1 = 8'($urandom_range(8'h80, 8'hBF));
            b2 = 8'($urandom_range(8'h80, 8'hBF));
            pick = $urandom_range(0, 2);
            if (pick != 2)
                b1 = rand_non_cont();
            if (pick != 1)
                b2 = rand_non_cont();
            text.push_back(b0);
            text.push_back(b1);
            text.push_back(b2);
        end
        else if (kind < 88)
        begin
            push_three(text, hi);
            b0 = 8'($urandom_range(0, 255));
            while (b0[7:4] == 4'hE)
                b0 = 8'($urandom_range(0, 255));
            text.push_back(b0);
        end
        else if (kind < 94)
        begin
            push_three(text, hi);
            if ($urandom_range(0, 1))
            begin
                lo = 16'($urandom_range(0, 16'hFFFF));
                while (lo[15:10] == 6'b110111)
                    lo = 16'($urandom_range(0, 16'hFFFF));
                push_three(text, lo);
            end
            else
            begin
                push_three(text, lo);
                idx = text.size() - 1 - $urandom_range(0, 1);
                text[idx] = rand_non_cont();
            end
        end
        else
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            else
            begin
                push_three(pair, hi);
                push_three(pair, lo);
                for (int i = 0; i < pick; i++)
                    text.push_back(pair[i]);
            end
            ended = 1;
        end
    endtask

    task automatic send_random_string();
        logic [7:0] text [$];
        int         segs;
        bit         ended;
        segs  = $urandom_range(1, 6);
        ended = 0;
        for (int s = 0; s < segs && !ended; s++)
            add_segment(text, ended);
        send_string(text);
    endtask

    initial
    begin
        int run_len;
        int stall_len;
        out_ready = 1'b0;
        forever
        begin
            run_len   = $urandom_range(1, 16);
            stall_len = calm ? 0 : $urandom_range(0, 8);
            repeat (stall_len)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            repeat (run_len)
            begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_byte, out_last, out_error);
    end

    initial
    begin
        sb         = new();
        processed  = 0;
        burst_left = 0;
        calm       = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        in_last    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Null byte, top byte value, the two-byte null and a raw two-byte pair.
        send_string('{8'h00, 8'hFF, 8'hC0, 8'h80, 8'hC0, 8'h41});
        // The highest supplementary code point from a surrogate pair.
        send_string('{8'hED, 8'hAF, 8'hBF, 8'hED, 8'hBF, 8'hBF});
        // A bad continuation byte in the second position of a three-byte sequence.
        send_string('{8'hE2, 8'h41, 8'hAC});
        // An unpaired high surrogate, with the tail of the string dropped.
        send_string('{8'hED, 8'hA0, 8'h80, 8'h41, 8'h7A});
        // A high surrogate followed by a value outside the low surrogate range.
        send_string('{8'hED, 8'hA0, 8'h80, 8'hED, 8'h80, 8'h80});
        // A two-byte prefix of a three-byte sequence is flushed at the end.
        send_string('{8'hE2, 8'h82});

        while (processed < 420)
        begin
            calm = ($urandom_range(0, 4) == 0);
            send_random_string();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mutf8_pkg.sv
rtl/mutf8_front.sv
rtl/mutf8_queue.sv
rtl/mutf8_back.sv
rtl/modified_utf8_to_utf8.sv
verif/modified_utf8_to_utf8_tb.sv
